### src/uss_pkg.sv
// Shared types, constants and helper functions for the UTF-8 sentence splitter.
// Used by uss_classify, the top level and the testbench; depends on nothing else.
package uss_pkg;

  // Depth of the whitespace hold store and the widths that follow from it.
  localparam int HOLD_DEPTH = 32;
  localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);

  // Request opcodes.
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Byte codes used by the delimiter and whitespace checks.
  localparam logic [7:0] B_SPACE   = 8'h20;
  localparam logic [7:0] B_TAB     = 8'h09;
  localparam logic [7:0] B_CR      = 8'h0D;
  localparam logic [7:0] B_NL      = 8'h0A;
  localparam logic [7:0] B_EXCL    = 8'h21;
  localparam logic [7:0] B_QUEST   = 8'h3F;
  localparam logic [7:0] B_SEMI    = 8'h3B;
  localparam logic [7:0] B_CJK_LD  = 8'hE3;
  localparam logic [7:0] B_CJK_MID = 8'h80;
  localparam logic [7:0] B_CJK_DOT = 8'h82;
  localparam logic [7:0] B_FW_LD   = 8'hEF;
  localparam logic [7:0] B_FW_MID  = 8'hBC;
  localparam logic [7:0] B_FW_EXCL = 8'h81;
  localparam logic [7:0] B_FW_QST  = 8'h9F;
  localparam logic [7:0] B_FW_SEMI = 8'h9B;

  // Input request payload.
  typedef struct packed {
    logic       opcode;
    logic [7:0] text_byte;
  } in_item_t;

  // Result payload.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       end_flag;
    logic       hold_overflow;
  } out_item_t;

  // Classification of one pushed byte.
  typedef struct packed {
    logic is_nl;
    logic is_ws;
    logic is_delim;
  } byte_class_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DRAIN = 4'b0010,
    S_OVF   = 4'b0100,
    S_LAST  = 4'b1000
  } state_t;

  // Advance a hold store pointer with wrap.
  function automatic logic [HOLD_AW-1:0] ptr_inc(input logic [HOLD_AW-1:0] p);
    logic [HOLD_AW-1:0] r;
    if ({1'b0, p} == (HOLD_AW+1)'(HOLD_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Slot after the newest held byte: head plus count, modulo the depth.
  function automatic logic [HOLD_AW-1:0] ptr_add(input logic [HOLD_AW-1:0] p,
                                                 input logic [CNT_W-1:0]   n);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(p) + (CNT_W+1)'(n);
    if (sum >= (CNT_W+1)'(HOLD_DEPTH)) begin
      sum = sum - (CNT_W+1)'(HOLD_DEPTH);
    end
    return sum[HOLD_AW-1:0];
  endfunction

endpackage

### src/uss_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
// Self-contained; a read at the address being written returns the old data.
module uss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/uss_classify.sv
// Byte classifier: whitespace, newline and sentence delimiter detection.
// Uses uss_pkg for byte codes and the classification struct.
module uss_classify
  import uss_pkg::*;
(
  input  logic [7:0]  cur_byte,
  input  logic [15:0] recent,
  input  logic [1:0]  recent_cnt,
  output byte_class_t cls
);

  logic [7:0] p1;
  logic [7:0] p2;
  logic       two_prev;
  logic       wide;
  logic       ascii_delim;

  assign p1       = recent[7:0];
  assign p2       = recent[15:8];
  assign two_prev = recent_cnt[1];

  // Full-width delimiters need the two preceding bytes of the sentence.
  always_comb begin
    wide = 1'b0;
    if (two_prev) begin
      if (p2 == B_CJK_LD && p1 == B_CJK_MID && cur_byte == B_CJK_DOT) begin
        wide = 1'b1;
      end
      if (p2 == B_FW_LD && p1 == B_FW_MID &&
          (cur_byte == B_FW_EXCL || cur_byte == B_FW_QST || cur_byte == B_FW_SEMI)) begin
        wide = 1'b1;
      end
    end
  end

  assign ascii_delim = (cur_byte == B_EXCL) || (cur_byte == B_QUEST) || (cur_byte == B_SEMI);

  assign cls.is_nl    = (cur_byte == B_NL);
  assign cls.is_ws    = (cur_byte == B_SPACE) || (cur_byte >= B_TAB && cur_byte <= B_CR);
  assign cls.is_delim = wide || ascii_delim;

endmodule

### src/utf8_sentence_splitter.sv
// Top level of the UTF-8 sentence splitter: sequencer, sentence state and hold store.
// Depends on uss_pkg, uss_classify and uss_ram.
//
// Usage: the in_ channel takes one request per accepted in_valid/in_ready
// handshake: a text byte (opcode push) or a flush that closes the open sentence.
// The out_ channel delivers result items, one per handshake, in stream order:
// sentence bytes, and end markers alone where a sentence closes on a newline or
// a flush. Inner whitespace is held in a 32-entry RAM ring and
// released in front of the next visible byte.
// A request that causes no result leaves the sequencer in S_IDLE. Otherwise
// the sequencer releases held bytes in S_DRAIN, one byte per cycle from the
// hold RAM read port while the output register is free, then gives the final
// result of the request in S_LAST; a hold store overflow passes through S_OVF.
// in_ready is low while the sequencer works on a request.
// Reset (rst_n low, synchronous) clears the sentence state, the hold count and
// the output valid flag; the hold RAM needs no clearing pass.
// When the receiver holds out_ready low, the output register keeps its item and
// the sequencer waits; no result is dropped.
module utf8_sentence_splitter
  import uss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  state_t             state_r,     state_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r,  out_data_nxt;
  out_item_t          pend_r,      pend_nxt;
  logic [15:0]        recent_r,    recent_nxt;
  logic [1:0]         rcnt_r,      rcnt_nxt;
  logic               started_r,   started_nxt;
  logic [HOLD_AW-1:0] head_r,      head_nxt;
  logic [CNT_W-1:0]   cnt_r,       cnt_nxt;

  logic               in_fire;
  logic               out_free;
  byte_class_t        cls;
  logic               ram_we;
  logic [HOLD_AW-1:0] ram_waddr;
  logic               ram_re;
  logic [HOLD_AW-1:0] ram_raddr;
  logic [7:0]         ram_rdata;
  logic               hold_full;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign hold_full = (cnt_r == CNT_W'(HOLD_DEPTH));

  // Delimiter and whitespace classification of the incoming byte.
  uss_classify u_classify (
    .cur_byte   (in_data.text_byte),
    .recent     (recent_r),
    .recent_cnt (rcnt_r),
    .cls        (cls)
  );

  // Whitespace hold store, a ring addressed by head and count.
  uss_ram #(
    .WIDTH (8),
    .DEPTH (HOLD_DEPTH)
  ) u_hold_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.text_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_waddr = ptr_add(head_r, cnt_r);

  // Sequencer and sentence state update.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pend_nxt      = pend_r;
    recent_nxt    = recent_r;
    rcnt_nxt      = rcnt_r;
    started_nxt   = started_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = head_r;

    case (state_r)
      S_IDLE: begin
        // Keep the oldest held byte on the read port for a release or overflow.
        ram_re = 1'b1;
        if (in_fire) begin
          if (in_data.opcode == OP_FLUSH || cls.is_nl) begin
            // Sentence closes; held whitespace is dropped.
            pend_nxt = '{has_byte: 1'b0, out_byte: 8'h00, end_flag: 1'b1,
                         hold_overflow: 1'b0};
            if (started_r) begin
              state_nxt = S_LAST;
            end
            recent_nxt  = '0;
            rcnt_nxt    = '0;
            started_nxt = 1'b0;
            cnt_nxt     = '0;
          end else if (cls.is_delim) begin
            // Visible delimiter: release held bytes, then the delimiter with the end flag.
            pend_nxt = '{has_byte: 1'b1, out_byte: in_data.text_byte, end_flag: 1'b1,
                         hold_overflow: 1'b0};
            state_nxt   = (cnt_r != '0) ? S_DRAIN : S_LAST;
            recent_nxt  = '0;
            rcnt_nxt    = '0;
            started_nxt = 1'b0;
          end else begin
            recent_nxt = {recent_r[7:0], in_data.text_byte};
            rcnt_nxt   = rcnt_r[1] ? rcnt_r : rcnt_r + 2'd1;
            if (cls.is_ws) begin
              // Inner whitespace goes to the ring; a full ring sheds its oldest byte.
              if (started_r) begin
                ram_we = 1'b1;
                if (hold_full) begin
                  head_nxt  = ptr_inc(head_r);
                  state_nxt = S_OVF;
                end else begin
                  cnt_nxt = cnt_r + 1'b1;
                end
              end
            end else begin
              // Visible byte: release held bytes first.
              pend_nxt = '{has_byte: 1'b1, out_byte: in_data.text_byte, end_flag: 1'b0,
                           hold_overflow: 1'b0};
              started_nxt = 1'b1;
              state_nxt   = (cnt_r != '0) ? S_DRAIN : S_LAST;
            end
          end
        end
      end
      S_DRAIN: begin
        // One held byte per cycle while the output side takes it.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{has_byte: 1'b1, out_byte: ram_rdata, end_flag: 1'b0,
                            hold_overflow: 1'b0};
          ram_re    = 1'b1;
          ram_raddr = ptr_inc(head_r);
          head_nxt  = ptr_inc(head_r);
          cnt_nxt   = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = S_LAST;
          end
        end
      end
      S_OVF: begin
        // Oldest held byte leaves early with the overflow flag.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{has_byte: 1'b1, out_byte: ram_rdata, end_flag: 1'b0,
                            hold_overflow: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      S_LAST: begin
        // Final result of the request.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pend_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      recent_r    <= '0;
      rcnt_r      <= '0;
      started_r   <= 1'b0;
      head_r      <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      recent_r    <= recent_nxt;
      rcnt_r      <= rcnt_nxt;
      started_r   <= started_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    pend_r     <= pend_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The hold count never exceeds the ring depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(HOLD_DEPTH))
    else $error("hold count above depth");

  // A drain is only entered or continued with bytes left to release.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> (cnt_r != '0))
    else $error("drain with empty hold store");

  // A flush leaves a closed sentence with nothing held.
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.opcode == OP_FLUSH) |=> (!started_r && cnt_r == '0))
    else $error("flush did not clear sentence state");

  // An overflow result is only produced from a full ring.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OVF) |-> hold_full)
    else $error("overflow emitted without a full hold store");

endmodule

### tb/uss_checker.sv
// Checker for the UTF-8 sentence splitter: watches the request and result channels, predicts the
// result items of every accepted request and compares them in order. Depends on uss_pkg.
`timescale 1ns / 1ps

module uss_checker
  import uss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatch_count,
  output int        items_owed
);

  // Sentence state kept by the predictor.
  logic [15:0] last_two;
  logic [1:0]  last_count;
  logic        started;
  logic [7:0]  held_blanks[$];

  // Result items predicted but not yet delivered, oldest first.
  out_item_t sentence_items_q[$];

  out_item_t want;
  int        fails = 0;

  task automatic expect_item(input logic has, input logic [7:0] b, input logic fin,
                             input logic ovf);
    out_item_t item;
    item = out_item_t'{has, b, fin, ovf};
    sentence_items_q.insert(sentence_items_q.size(), item);
  endtask

  // Held whitespace goes out in front of the next visible byte.
  task automatic release_held();
    while (held_blanks.size() != 0) begin
      expect_item(1'b1, held_blanks.pop_front(), 1'b0, 1'b0);
    end
  endtask

  task automatic clear_sentence();
    last_two   = '0;
    last_count = '0;
    started    = 1'b0;
    held_blanks.delete();
  endtask

  // Works out the result items that one accepted request causes.
  task automatic split_request(input in_item_t req);
    logic [7:0] b;
    logic       wide;
    b    = req.text_byte;
    wide = 1'b0;
    if (last_count == 2'd2) begin
      if (last_two == {B_CJK_LD, B_CJK_MID} && b == B_CJK_DOT) begin
        wide = 1'b1;
      end
      if (last_two == {B_FW_LD, B_FW_MID} &&
          (b == B_FW_EXCL || b == B_FW_QST || b == B_FW_SEMI)) begin
        wide = 1'b1;
      end
    end
    if (req.opcode == OP_FLUSH || b == B_NL) begin
      // Flush and newline drop held whitespace; an end marker only for a started sentence.
      if (started) begin
        expect_item(1'b0, 8'h00, 1'b1, 1'b0);
      end
      clear_sentence();
    end else if (wide || b == B_EXCL || b == B_QUEST || b == B_SEMI) begin
      // A visible delimiter closes the sentence and carries the end flag itself.
      release_held();
      expect_item(1'b1, b, 1'b1, 1'b0);
      clear_sentence();
    end else begin
      last_two = {last_two[7:0], b};
      if (last_count != 2'd2) begin
        last_count = last_count + 2'd1;
      end
      if (b == B_SPACE || (b >= B_TAB && b <= B_CR)) begin
        // Leading whitespace is dropped; a full store pushes its oldest byte out early.
        if (started) begin
          if (held_blanks.size() >= HOLD_DEPTH) begin
            expect_item(1'b1, held_blanks.pop_front(), 1'b0, 1'b1);
          end
          held_blanks.insert(held_blanks.size(), b);
        end
      end else begin
        release_held();
        expect_item(1'b1, b, 1'b0, 1'b0);
        started = 1'b1;
      end
    end
  endtask

  function automatic int field_diff(input string field, input logic [7:0] exp_val,
                                    input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  // Requests accepted at this edge are predicted first; their results pass through the
  // sequencer state and the output register, so the oldest expectation is never one of them.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_sentence();
      sentence_items_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        split_request(in_data);
      end
      if (out_valid && out_ready) begin
        if (sentence_items_q.size() == 0) begin
          $error("result with no expectation: has_byte %0d out_byte 0x%0h end %0d ovf %0d",
                 out_data.has_byte, out_data.out_byte, out_data.end_flag,
                 out_data.hold_overflow);
          fails++;
        end else begin
          want = sentence_items_q.pop_front();
          fails += field_diff("has_byte", want.has_byte, out_data.has_byte);
          fails += field_diff("out_byte", want.out_byte, out_data.out_byte);
          fails += field_diff("end_flag", want.end_flag, out_data.end_flag);
          fails += field_diff("hold_overflow", want.hold_overflow, out_data.hold_overflow);
        end
      end
    end
    mismatch_count <= fails;
    items_owed     <= sentence_items_q.size();
  end

endmodule

### tb/tb_utf8_sentence_splitter.sv
// Testbench top for utf8_sentence_splitter: clock, reset, request stimulus, receiver
// stalls and the verdict. Depends on uss_pkg, the block and uss_checker.
`timescale 1ns / 1ps

module tb_utf8_sentence_splitter;
  import uss_pkg::*;

  localparam int RANDOM_ITEMS   = 455;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int LAT_PAUSE      = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int   mismatch_count;
  int   items_owed;
  int   item_count = 0;
  int   idle_cycles = 0;
  int   rx_hold_ask = 0;
  int   rx_hold_seen = 0;
  logic no_idle = 1'b0;
  bit   hold_done = 0;
  bit   pause_done = 0;

  utf8_sentence_splitter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  uss_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .items_owed    (items_owed)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver: random stalls, a quiet stretch, and a long hold-off when one is asked for.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_ask != rx_hold_seen) begin
        rx_hold_seen = rx_hold_ask;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 9);
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offers one request and returns once it has been taken, sometimes idling afterwards.
  task automatic send_request(input logic op, input logic [7:0] b);
    in_data  <= in_item_t'{opcode: op, text_byte: b};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    item_count++;
    if (!no_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // Whitespace other than newline, half of them spaces.
  function automatic logic [7:0] pick_blank();
    logic [7:0] b;
    case ($urandom_range(7))
      0: b = B_TAB;
      1: b = B_TAB + 8'd2;  // vertical tab
      2: b = B_TAB + 8'd3;  // form feed
      3: b = B_CR;
      default: b = B_SPACE;
    endcase
    return b;
  endfunction

  // A visible byte that is neither whitespace nor a one-byte delimiter.
  function automatic logic [7:0] pick_glyph();
    logic [7:0] b;
    if ($urandom_range(1) == 0) begin
      b = 8'($urandom_range(8'h7A, 8'h41));
    end else begin
      do b = 8'($urandom_range(255));
      while (b == B_NL || b == B_EXCL || b == B_QUEST || b == B_SEMI || b == B_SPACE ||
             (b >= B_TAB && b <= B_CR));
    end
    return b;
  endfunction

  task automatic send_blanks(input int n);
    repeat (n) send_request(OP_PUSH, pick_blank());
  endtask

  // A word: plain bytes, or a three-byte character that may turn out to be a delimiter.
  task automatic send_word();
    int len;
    if ($urandom_range(4) == 0) begin
      send_request(OP_PUSH, $urandom_range(1) ? B_CJK_LD : B_FW_LD);
      send_request(OP_PUSH, $urandom_range(1) ? B_CJK_MID : B_FW_MID);
      send_request(OP_PUSH, 8'($urandom_range(8'hBF, 8'h80)));
    end else begin
      len = $urandom_range(6, 1);
      repeat (len) send_request(OP_PUSH, pick_glyph());
    end
  endtask

  // A well-formed sentence with random words, gaps and terminator.
  task automatic send_sentence();
    int words;
    words = $urandom_range(5, 1);
    send_blanks($urandom_range(2));
    repeat (words) begin
      send_word();
      // Now and then a long run that can overflow the hold store.
      if ($urandom_range(15) == 0) begin
        send_blanks($urandom_range(40, 30));
      end else begin
        send_blanks($urandom_range(3));
      end
    end
    case ($urandom_range(9))
      0: send_request(OP_PUSH, B_EXCL);
      1: send_request(OP_PUSH, B_QUEST);
      2: send_request(OP_PUSH, B_SEMI);
      3: send_request(OP_PUSH, B_NL);
      4: begin
        send_request(OP_PUSH, B_CJK_LD);
        send_request(OP_PUSH, B_CJK_MID);
        send_request(OP_PUSH, B_CJK_DOT);
      end
      5, 6, 7: begin
        send_request(OP_PUSH, B_FW_LD);
        send_request(OP_PUSH, B_FW_MID);
        case ($urandom_range(2))
          0: send_request(OP_PUSH, B_FW_EXCL);
          1: send_request(OP_PUSH, B_FW_QST);
          default: send_request(OP_PUSH, B_FW_SEMI);
        endcase
      end
      8: send_request(OP_FLUSH, 8'($urandom_range(255)));
      default: ;  // runs on into the next sentence
    endcase
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty sentences: flush and newline with nothing started.
    send_request(OP_FLUSH, 8'hFF);
    send_request(OP_PUSH, B_NL);
    // Leading whitespace dropped, inner runs held and released before visible bytes.
    send_request(OP_PUSH, B_SPACE);
    send_request(OP_PUSH, B_TAB);
    send_request(OP_PUSH, 8'h41);
    send_request(OP_PUSH, B_CR);
    send_request(OP_PUSH, B_TAB + 8'd2);
    send_request(OP_PUSH, 8'h62);
    // Held space released in front of an ASCII delimiter; then a delimiter alone.
    send_request(OP_PUSH, B_SPACE);
    send_request(OP_PUSH, B_EXCL);
    send_request(OP_PUSH, B_QUEST);
    // Sentence ending on whitespace and newline: end marker alone.
    send_request(OP_PUSH, 8'h78);
    send_request(OP_PUSH, B_SPACE);
    send_request(OP_PUSH, B_NL);
    // Full-width period and semicolon.
    send_request(OP_PUSH, B_CJK_LD);
    send_request(OP_PUSH, B_CJK_MID);
    send_request(OP_PUSH, B_CJK_DOT);
    send_request(OP_PUSH, B_FW_LD);
    send_request(OP_PUSH, B_FW_MID);
    send_request(OP_PUSH, B_FW_SEMI);
    // Byte extremes, flush of a started sentence, semicolon alone.
    send_request(OP_PUSH, 8'h7A);
    send_request(OP_PUSH, 8'hFF);
    send_request(OP_PUSH, 8'h00);
    send_request(OP_FLUSH, 8'h00);
    send_request(OP_PUSH, B_SEMI);

    // Random part: mostly well-formed sentences, some raw noise.
    while (item_count < RANDOM_ITEMS + 25) begin
      if (!hold_done && item_count >= 150) begin
        rx_hold_ask <= rx_hold_ask + 1;
        hold_done = 1;
      end
      if (!pause_done && item_count >= 320) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (items_owed != 0);
        repeat (LAT_PAUSE) @(posedge clk);
        pause_done = 1;
      end
      no_idle <= (item_count >= 220 && item_count < 300);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(8, 1)) begin
          send_request(($urandom_range(9) == 0) ? OP_FLUSH : OP_PUSH, 8'($urandom_range(255)));
        end
      end else begin
        send_sentence();
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (items_owed != 0);
    repeat (LAT_PAUSE) @(posedge clk);
    if (mismatch_count == 0 && items_owed == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
src/uss_pkg.sv
src/uss_ram.sv
src/uss_classify.sv
src/utf8_sentence_splitter.sv
tb/uss_checker.sv
tb/tb_utf8_sentence_splitter.sv
